### rtl/ppu_pkg.sv
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types and constants for the packed pixel to RGBA unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package ppu_pkg;

  // configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int DIM_REG_W  = 13;
  localparam int PAD_W      = 8;

  // source pixel formats
  typedef enum logic [1:0] {
    MODE_RGBA8888 = 2'd0,
    MODE_RGBA4444 = 2'd1,
    MODE_RGB888   = 2'd2,
    MODE_RGB565   = 2'd3
  } pix_mode_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_MODE    = 2'd0,
    REG_IMAGE_WIDTH   = 2'd1,
    REG_IMAGE_HEIGHT  = 2'd2,
    REG_ROW_PAD_BYTES = 2'd3
  } reg_idx_t;

  // configuration register set
  typedef struct packed {
    pix_mode_t              mode;
    logic [DIM_REG_W-1:0]   width;
    logic [DIM_REG_W-1:0]   height;
    logic [PAD_W-1:0]       pad;
  } cfg_t;

  // one complete source pixel, handed from front to back
  typedef struct packed {
    pix_mode_t  mode;
    logic [7:0] h0;
    logic [7:0] h1;
    logic [7:0] h2;
    logic [7:0] last;
    logic       row_end;
    logic       image_end;
  } pix_job_t;

  // expanded output word
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       image_end;
  } rgba_t;

endpackage

`default_nettype wire

### rtl/ppu_front.sv
// ----------------------------------------------------------------------------
// ppu_front
// Byte assembly, row padding skip and row/image position tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_front #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      data_byte,
  input  wire ppu_pkg::cfg_t   cfg,
  output logic                 job_valid,
  output ppu_pkg::pix_job_t    job
);
  import ppu_pkg::*;

  localparam int CW   = $clog2(MAX_DIM);
  localparam int CMPW = (CW + 1 > DIM_REG_W) ? CW + 1 : DIM_REG_W;

  logic [1:0]       phase;
  logic [23:0]      held;
  logic [CW-1:0]    col;
  logic [CW-1:0]    row;
  logic [PAD_W-1:0] pad_left;

  logic [2:0]       bpp;
  logic [CMPW-1:0]  width_lim;
  logic [CMPW-1:0]  height_lim;
  logic             padding;
  logic             completes;
  logic             col_last;
  logic             row_last;

  // limit a size register to 1..MAX_DIM
  function automatic logic [CMPW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
    logic [CMPW-1:0] ext;
    ext = CMPW'(v);
    if (ext == '0) begin
      return CMPW'(1);
    end else if (ext > CMPW'(MAX_DIM)) begin
      return CMPW'(MAX_DIM);
    end
    return ext;
  endfunction

  // bytes per source pixel
  always_comb begin
    case (cfg.mode)
      MODE_RGBA8888: bpp = 3'd4;
      MODE_RGB888:   bpp = 3'd3;
      default:       bpp = 3'd2;
    endcase
  end

  assign width_lim  = clamp_dim(cfg.width);
  assign height_lim = clamp_dim(cfg.height);
  assign padding    = (pad_left != '0);
  assign completes  = !padding && ((3'(phase) + 3'd1) >= bpp);
  assign col_last   = (CMPW'(col) + CMPW'(1)) >= width_lim;
  assign row_last   = (CMPW'(row) + CMPW'(1)) >= height_lim;

  // job for the back end
  assign job_valid     = accept && completes;
  assign job.mode      = cfg.mode;
  assign job.h0        = held[7:0];
  assign job.h1        = held[15:8];
  assign job.h2        = held[23:16];
  assign job.last      = data_byte;
  assign job.row_end   = col_last;
  assign job.image_end = col_last && row_last;

  // byte phase, held bytes and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= '0;
      held     <= '0;
      col      <= '0;
      row      <= '0;
      pad_left <= '0;
    end else if (accept) begin
      if (padding) begin
        pad_left <= pad_left - PAD_W'(1);
      end else if (!completes) begin
        case (phase)
          2'd0:    held[7:0]   <= data_byte;
          2'd1:    held[15:8]  <= data_byte;
          default: held[23:16] <= data_byte;
        endcase
        phase <= phase + 2'd1;
      end else begin
        phase <= '0;
        held  <= '0;
        if (col_last) begin
          col      <= '0;
          pad_left <= cfg.pad;
          if (row_last) begin
            row <= '0;
          end else begin
            row <= row + CW'(1);
          end
        end else begin
          col <= col + CW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ppu_fifo.sv
// ----------------------------------------------------------------------------
// ppu_fifo
// Two-entry queue of pixel jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire ppu_pkg::pix_job_t wr_data,
  input  wire logic              rd_en,
  output ppu_pkg::pix_job_t      rd_data,
  output logic                   is_full,
  output logic                   is_empty
);
  import ppu_pkg::*;

  pix_job_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign is_full  = (count == 2'd2);
  assign is_empty = (count == 2'd0);
  assign rd_data  = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/ppu_back.sv
// ----------------------------------------------------------------------------
// ppu_back
// Channel expansion to RGBA8888 and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              job_ready,
  input  wire ppu_pkg::pix_job_t job,
  output logic                   job_take,
  input  wire logic              pop,
  output logic                   empty,
  output ppu_pkg::rgba_t         word
);
  import ppu_pkg::*;

  logic  out_valid;
  rgba_t expanded;

  // format expansion
  always_comb begin
    expanded.row_end   = job.row_end;
    expanded.image_end = job.image_end;
    case (job.mode)
      MODE_RGBA8888: begin
        expanded.red   = job.h0;
        expanded.green = job.h1;
        expanded.blue  = job.h2;
        expanded.alpha = job.last;
      end
      MODE_RGBA4444: begin
        expanded.red   = {job.last[7:4], 4'h0};
        expanded.green = {job.last[3:0], 4'h0};
        expanded.blue  = {job.h0[7:4], 4'h0};
        expanded.alpha = {job.h0[3:0], 4'h0};
      end
      MODE_RGB888: begin
        expanded.red   = job.h0;
        expanded.green = job.h1;
        expanded.blue  = job.last;
        expanded.alpha = 8'hFF;
      end
      default: begin
        expanded.red   = {job.last[7:3], 3'b000};
        expanded.green = {job.last[2:0], job.h0[7:5], 2'b00};
        expanded.blue  = {job.h0[4:0], 3'b000};
        expanded.alpha = 8'hFF;
      end
    endcase
  end

  // load when the output register is free or being drained
  assign job_take = job_ready && (!out_valid || pop);
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (job_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      word <= expanded;
    end
  end

endmodule

`default_nettype wire

### rtl/packed_pixel_to_rgba_unpacker_top.sv
// ----------------------------------------------------------------------------
// packed_pixel_to_rgba_unpacker_top
// Unpacks a packed source image byte stream into RGBA8888 pixels.
//
//   channel   handshake            payload
//   input     push / full          data_byte
//   result    empty / pop          red green blue alpha row_end image_end
//   config    cfg_valid/cfg_ready  cfg_index cfg_data
//
// One byte is taken every cycle while full is low; full is high exactly while
// the two-entry job queue holds two pixels, whatever pop does in that cycle.
// A pixel whose last byte is accepted is written into the job queue and then
// loaded into the output word that drives the result ports; the queue drains
// one pixel per cycle into the output word as words are popped.
// Synchronous reset clears position state, queue and output; config
// registers reset to rgba8888, 1x1, no padding. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_pixel_to_rgba_unpacker_top #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [7:0]                     data_byte,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [7:0]                          red,
  output logic [7:0]                          green,
  output logic [7:0]                          blue,
  output logic [7:0]                          alpha,
  output logic                                row_end,
  output logic                                image_end,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ppu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ppu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ppu_pkg::*;

  cfg_t     cfg;
  logic     accept;
  logic     job_push;
  pix_job_t job_in;
  pix_job_t job_out;
  logic     q_full;
  logic     q_empty;
  logic     job_take;
  rgba_t    word;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= MODE_RGBA8888;
      cfg.width  <= DIM_REG_W'(1);
      cfg.height <= DIM_REG_W'(1);
      cfg.pad    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_PIXEL_MODE:    cfg.mode   <= pix_mode_t'(cfg_data[1:0]);
        REG_IMAGE_WIDTH:   cfg.width  <= cfg_data[DIM_REG_W-1:0];
        REG_IMAGE_HEIGHT:  cfg.height <= cfg_data[DIM_REG_W-1:0];
        REG_ROW_PAD_BYTES: cfg.pad    <= cfg_data[PAD_W-1:0];
        default:           cfg.pad    <= cfg.pad;
      endcase
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  // byte assembly
  ppu_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .cfg       (cfg),
    .job_valid (job_push),
    .job       (job_in)
  );

  // job queue
  ppu_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_push),
    .wr_data  (job_in),
    .rd_en    (job_take),
    .rd_data  (job_out),
    .is_full  (q_full),
    .is_empty (q_empty)
  );

  // expansion and output word
  ppu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_ready (!q_empty),
    .job       (job_out),
    .job_take  (job_take),
    .pop       (pop),
    .empty     (empty),
    .word      (word)
  );

  assign red       = word.red;
  assign green     = word.green;
  assign blue      = word.blue;
  assign alpha     = word.alpha;
  assign row_end   = word.row_end;
  assign image_end = word.image_end;

endmodule

`default_nettype wire
